// ===== hw/rtl/positioner_pid_leaky_integral_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positioner regulator
// Implication checks on a clock with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONER_PID_LEAKY_INTEGRAL_ASSERT_SVH
`define POSITIONER_PID_LEAKY_INTEGRAL_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: when ante holds, cons must hold on that edge.
`define PPLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define PPLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PPLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ppli_pkg.sv =====
// ----------------------------------------------------------------------------
// ppli_pkg
// Shared constants, codes and the register bank type of the positioner.
// ----------------------------------------------------------------------------
package ppli_pkg;

	localparam int POS_BITS_DEF      = 12;
	localparam int INTEGRAL_BITS_DEF = 32;

	localparam int GAIN_W      = 24;
	localparam int MAXD_W      = 15;
	localparam int DECAY_W     = 16;
	localparam int END_W       = 12;
	localparam int DRIVE_W     = MAXD_W + 1;
	localparam int MODE_W      = 3;
	localparam int ANGLE_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// Gains are Q4.20 and the drive is Q1.15.
	localparam int DRIVE_SHIFT = 5;
	// The integral operand of its product is held within plus or minus 2^38.
	localparam int PROD_LIM_SHIFT = 38;

	localparam int ANGLE_OFFSET = 90;
	localparam int ANGLE_SPAN   = 180;
	localparam int NUDGE_STEP   = 1;

	localparam logic [MODE_W-1:0] MODE_SAMPLE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_AIM      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CENTRE   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_NUDGE_DN = 3'd5;
	localparam logic [MODE_W-1:0] MODE_NUDGE_UP = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RAW      = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_LEFT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_RIGHT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE    = 3'd7;

	localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 24'd2621;
	localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 24'd0;
	localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 24'd0;
	localparam logic [MAXD_W-1:0]  RST_MAX_DRIVE = 15'd32767;
	localparam logic [DECAY_W-1:0] RST_DECAY     = 16'd65535;
	localparam logic [END_W-1:0]   RST_END_LEFT  = 12'd0;
	localparam logic [END_W-1:0]   RST_END_RIGHT = 12'd4095;
	localparam logic [END_W-1:0]   RST_CENTRE    = 12'd2048;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [MAXD_W-1:0]  max_drive;
		logic [DECAY_W-1:0] decay;
		logic [END_W-1:0]   end_left;
		logic [END_W-1:0]   end_right;
		logic [END_W-1:0]   centre_pos;
	} cfg_t;

endpackage

// ===== hw/rtl/ppli_cfg.sv =====
// ----------------------------------------------------------------------------
// ppli_cfg
// Configuration register bank, written one register per cycle.
// ----------------------------------------------------------------------------
module ppli_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [ppli_pkg::CFG_IDX_W-1:0]   index,
	input  logic [ppli_pkg::CFG_DATA_W-1:0]  wdata,
	output ppli_pkg::cfg_t                   cfg
);
	import ppli_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= RST_GAIN_P;
			cfg_q.gain_i     <= RST_GAIN_I;
			cfg_q.gain_d     <= RST_GAIN_D;
			cfg_q.max_drive  <= RST_MAX_DRIVE;
			cfg_q.decay      <= RST_DECAY;
			cfg_q.end_left   <= RST_END_LEFT;
			cfg_q.end_right  <= RST_END_RIGHT;
			cfg_q.centre_pos <= RST_CENTRE;
		end else if (wr_en) begin
			case (index)
				REG_GAIN_P:    cfg_q.gain_p     <= wdata[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i     <= wdata[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d     <= wdata[GAIN_W-1:0];
				REG_MAX_DRIVE: cfg_q.max_drive  <= wdata[MAXD_W-1:0];
				REG_DECAY:     cfg_q.decay      <= wdata[DECAY_W-1:0];
				REG_END_LEFT:  cfg_q.end_left   <= wdata[END_W-1:0];
				REG_END_RIGHT: cfg_q.end_right  <= wdata[END_W-1:0];
				REG_CENTRE:    cfg_q.centre_pos <= wdata[END_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ppli_target.sv =====
// ----------------------------------------------------------------------------
// ppli_target
// Target position register and the command decoding that moves it.
// ----------------------------------------------------------------------------
module ppli_target #(
	parameter int POS_BITS = ppli_pkg::POS_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [ppli_pkg::ANGLE_W-1:0]  angle,
	input  logic                                 update,
	input  logic [ppli_pkg::MODE_W-1:0]          mode,
	input  logic [POS_BITS-1:0]                  position,
	input  logic                                 limit_hit,
	input  ppli_pkg::cfg_t                       cfg,
	output logic [POS_BITS-1:0]                  target_q,
	output logic [POS_BITS-1:0]                  target_next
);
	import ppli_pkg::*;

	localparam int SPAN_W    = POS_BITS + 1;
	localparam int AOFF_W    = ANGLE_W + 1;
	localparam int PROD_W    = SPAN_W + AOFF_W;
	// The offset angle stays below 2^ANGLE_W, so the product magnitude fits here.
	localparam int MAG_W     = POS_BITS + ANGLE_W;
	localparam int REC_GUARD = 8;
	localparam int REC_SHIFT = MAG_W + REC_GUARD;
	localparam longint unsigned REC_K =
		((longint'(1) << REC_SHIFT) + ANGLE_SPAN - 1) / ANGLE_SPAN;
	localparam int REC_W     = REC_SHIFT - 6;
	localparam int Q_W       = POS_BITS + 1;
	localparam int SQ_W      = POS_BITS + 2;
	localparam int T_W       = POS_BITS + 3;
	localparam int EXT_W     = (POS_BITS > END_W) ? POS_BITS : END_W;
	localparam logic [POS_BITS-1:0]  POS_MAX = {POS_BITS{1'b1}};
	localparam logic signed [T_W-1:0] AIM_MAX = T_W'(POS_MAX);

	function automatic logic [POS_BITS-1:0] sat_end(input logic [END_W-1:0] v);
		logic [EXT_W-1:0] ve;
		ve = EXT_W'(v);
		if (ve > EXT_W'(POS_MAX))
			return POS_MAX;
		return ve[POS_BITS-1:0];
	endfunction

	logic [POS_BITS-1:0]             left_pos;
	logic [POS_BITS-1:0]             right_pos;
	logic signed [SPAN_W-1:0]        span;
	logic signed [AOFF_W-1:0]        aoff;
	logic signed [PROD_W-1:0]        prod_s1;
	logic [PROD_W-1:0]               pabs;
	logic [MAG_W+REC_W-1:0]          qprod;
	logic [Q_W-1:0]                  quot;
	logic signed [SQ_W-1:0]          squot;
	logic signed [T_W-1:0]           aim;
	logic [POS_BITS-1:0]             aim_sat;

	assign left_pos  = sat_end(cfg.end_left);
	assign right_pos = sat_end(cfg.end_right);
	assign span      = $signed({1'b0, right_pos}) - $signed({1'b0, left_pos});
	assign aoff      = AOFF_W'(angle + ANGLE_OFFSET);

	// The angle product is formed as the word enters; the user must change the ends only while idle (not enforced).
	always_ff @(posedge clk) begin
		if (load)
			prod_s1 <= aoff * span;
	end

	// Division by the angle span is a reciprocal multiply, exact over the product range.
	assign pabs  = prod_s1[PROD_W-1] ? $unsigned(-prod_s1) : $unsigned(prod_s1);
	assign qprod = pabs[MAG_W-1:0] * REC_W'(REC_K);
	assign quot  = qprod[REC_SHIFT+Q_W-1:REC_SHIFT];
	assign squot = prod_s1[PROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign aim   = T_W'($signed({1'b0, left_pos})) + T_W'(squot);

	always_comb begin
		if (aim < 0)
			aim_sat = '0;
		else if (aim > AIM_MAX)
			aim_sat = POS_MAX;
		else
			aim_sat = aim[POS_BITS-1:0];
	end

	always_comb begin
		case (mode)
			MODE_AIM:    target_next = aim_sat;
			MODE_LEFT:   target_next = left_pos;
			MODE_RIGHT:  target_next = right_pos;
			MODE_CENTRE: target_next = sat_end(cfg.centre_pos);
			MODE_NUDGE_DN: begin
				if (!limit_hit && target_q != '0)
					target_next = target_q - POS_BITS'(NUDGE_STEP);
				else
					target_next = target_q;
			end
			MODE_NUDGE_UP: begin
				if (!limit_hit && target_q != POS_MAX)
					target_next = target_q + POS_BITS'(NUDGE_STEP);
				else
					target_next = target_q;
			end
			MODE_RAW:    target_next = position;
			default:     target_next = target_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_q <= '0;
		else if (update)
			target_q <= target_next;
	end

endmodule

// ===== hw/rtl/ppli_pid.sv =====
// ----------------------------------------------------------------------------
// ppli_pid
// Error, leaky saturating integral, derivative and clamped drive sum.
// ----------------------------------------------------------------------------
module ppli_pid #(
	parameter int POS_BITS      = ppli_pkg::POS_BITS_DEF,
	parameter int INTEGRAL_BITS = ppli_pkg::INTEGRAL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 update,
	input  logic [POS_BITS-1:0]                  position,
	input  logic [POS_BITS-1:0]                  target,
	input  ppli_pkg::cfg_t                       cfg,
	output logic signed [ppli_pkg::DRIVE_W-1:0]  drive
);
	import ppli_pkg::*;

	localparam int IB     = INTEGRAL_BITS;
	localparam int ERR_W  = POS_BITS + 1;
	localparam int DER_W  = POS_BITS + 2;
	localparam int IOP_W  = (IB > PROD_LIM_SHIFT + 1) ? PROD_LIM_SHIFT + 2 : IB;
	localparam int PP_W   = ERR_W + GAIN_W;
	localparam int PD_W   = DER_W + GAIN_W;
	localparam int PI_W   = IOP_W + GAIN_W;
	localparam int SUM_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
	localparam int LIM_W  = MAXD_W + DRIVE_SHIFT;
	localparam logic signed [IB-1:0] INT_MAX = {1'b0, {(IB-1){1'b1}}};
	localparam logic signed [IB-1:0] INT_MIN = {1'b1, {(IB-1){1'b0}}};

	logic signed [IB-1:0]        integral_q;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic signed [ERR_W-1:0]     err;
	logic signed [DER_W-1:0]     der;
	logic signed [IB:0]          isum;
	logic signed [IB-1:0]        int_sat;
	logic signed [IOP_W-1:0]     iop;
	logic signed [PP_W-1:0]      prod_p;
	logic signed [PI_W-1:0]      prod_i;
	logic signed [PD_W-1:0]      prod_d;
	logic signed [SUM_W-1:0]     sum;
	logic signed [SUM_W-1:0]     lim;
	logic signed [DRIVE_W-1:0]   drive_max;
	logic [IB-1:0]               mag;
	logic [IB+DECAY_W-1:0]       dprod;
	logic [IB-1:0]               dres;
	logic signed [IB-1:0]        int_next;

	assign err  = $signed({1'b0, position}) - $signed({1'b0, target});
	assign der  = err - prev_err_q;
	assign isum = integral_q + err;

	always_comb begin
		if (isum[IB] != isum[IB-1])
			int_sat = isum[IB] ? INT_MIN : INT_MAX;
		else
			int_sat = isum[IB-1:0];
	end

	generate
		if (IB > PROD_LIM_SHIFT + 1) begin : g_clip
			localparam logic signed [IB-1:0] PLIM_HI = IB'(longint'(1) << PROD_LIM_SHIFT);
			localparam logic signed [IB-1:0] PLIM_LO = -PLIM_HI;
			always_comb begin
				if (int_sat > PLIM_HI)
					iop = PLIM_HI[IOP_W-1:0];
				else if (int_sat < PLIM_LO)
					iop = PLIM_LO[IOP_W-1:0];
				else
					iop = int_sat[IOP_W-1:0];
			end
		end else begin : g_pass
			assign iop = int_sat;
		end
	endgenerate

	assign prod_p = err * $signed(cfg.gain_p);
	assign prod_i = iop * $signed(cfg.gain_i);
	assign prod_d = der * $signed(cfg.gain_d);
	assign sum    = prod_p + prod_i + prod_d;

	assign lim       = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.max_drive, {DRIVE_SHIFT{1'b0}}});
	assign drive_max = $signed({1'b0, cfg.max_drive});

	// Inside the limit the sum is small enough that the shifted bits carry the sign.
	always_comb begin
		if (sum > lim)
			drive = drive_max;
		else if (sum < -lim)
			drive = -drive_max;
		else
			drive = sum[LIM_W:DRIVE_SHIFT];
	end

	// Leak: magnitude times decay, truncated toward zero, sign put back.
	assign mag      = int_sat[IB-1] ? $unsigned(-int_sat) : $unsigned(int_sat);
	assign dprod    = mag * cfg.decay;
	assign dres     = dprod[IB+DECAY_W-1:DECAY_W];
	assign int_next = int_sat[IB-1] ? -$signed(dres) : $signed(dres);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (update) begin
			integral_q <= int_next;
			prev_err_q <= err;
		end
	end

endmodule

// ===== hw/rtl/positioner_pid_leaky_integral.sv =====
// ----------------------------------------------------------------------------
// positioner_pid_leaky_integral
// Position regulator with a leaky saturating integral and a clamped drive.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output side is ready and returns
// one result word per input word, held first in the input stage and then in the
// output register. The target, integral and previous-error registers update as a
// word moves from the input stage to the output register. A sample word (mode 0)
// yields a new drive with tuser high; command words move the target and return
// drive zero with tuser low. Every result word carries the target after that word.
// Configuration registers are written through the plain write port; the user must
// write them only while no word is in flight, which the block does not enforce.
module positioner_pid_leaky_integral #(
	parameter int POS_BITS      = ppli_pkg::POS_BITS_DEF,
	parameter int INTEGRAL_BITS = ppli_pkg::INTEGRAL_BITS_DEF,
	localparam int IN_W         = ((POS_BITS + ppli_pkg::ANGLE_W + 1 + 7) / 8) * 8,
	localparam int OUT_W        = ((POS_BITS + ppli_pkg::DRIVE_W + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// position, angle, limit_hit
	input  logic [IN_W-1:0]                     s_axis_tdata,
	// mode
	input  logic [ppli_pkg::MODE_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// drive, target_next
	output logic [OUT_W-1:0]                    m_axis_tdata,
	// drive_valid
	output logic                                m_axis_tuser,
	input  logic                                cfg_wr_en,
	input  logic [ppli_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppli_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ppli_pkg::*;

`include "positioner_pid_leaky_integral_assert.svh"

	cfg_t                       cfg;
	logic                       accept;
	logic                       advance;
	logic                       valid_s1;
	logic [MODE_W-1:0]          mode_s1;
	logic [POS_BITS-1:0]        pos_s1;
	logic                       limit_s1;
	logic                       sample_s1;
	logic [POS_BITS-1:0]        target_now;
	logic [POS_BITS-1:0]        target_next;
	logic signed [DRIVE_W-1:0]  drive;
	logic                       valid_s2;
	logic signed [DRIVE_W-1:0]  drive_s2;
	logic                       dvalid_s2;
	logic [POS_BITS-1:0]        target_s2;
	logic signed [DRIVE_W-1:0]  drive_lim;
	logic signed [DRIVE_W-1:0]  drive_lim_n;

	ppli_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// The input stage moves on whenever the output register is free or being drained.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= s_axis_tuser;
			pos_s1   <= s_axis_tdata[POS_BITS-1:0];
			limit_s1 <= s_axis_tdata[POS_BITS+ANGLE_W];
		end
	end

	assign sample_s1 = (mode_s1 == MODE_SAMPLE);

	ppli_target #(
		.POS_BITS (POS_BITS)
	) u_target (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.angle       ($signed(s_axis_tdata[POS_BITS+ANGLE_W-1:POS_BITS])),
		.update      (advance),
		.mode        (mode_s1),
		.position    (pos_s1),
		.limit_hit   (limit_s1),
		.cfg         (cfg),
		.target_q    (target_now),
		.target_next (target_next)
	);

	ppli_pid #(
		.POS_BITS      (POS_BITS),
		.INTEGRAL_BITS (INTEGRAL_BITS)
	) u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (advance && sample_s1),
		.position (pos_s1),
		.target   (target_now),
		.cfg      (cfg),
		.drive    (drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_axis_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2  <= sample_s1 ? drive : '0;
			dvalid_s2 <= sample_s1;
			target_s2 <= target_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = dvalid_s2;
	assign m_axis_tdata  = OUT_W'({target_s2, drive_s2});

	assign drive_lim   = $signed({1'b0, cfg.max_drive});
	assign drive_lim_n = -drive_lim;

	`PPLI_ASSERT_IMP(a_cmd_no_drive, clk, arst_n, m_axis_tvalid && !m_axis_tuser, drive_s2 == '0, "command word carries a nonzero drive")
	`PPLI_ASSERT_IMP(a_drive_clamped, clk, arst_n, m_axis_tvalid && m_axis_tuser, (drive_s2 <= drive_lim) && (drive_s2 >= drive_lim_n), "drive outside the configured limit")
	`PPLI_ASSERT_NXT(a_target_hold, clk, arst_n, !advance, $stable(target_now), "target moved without a word advancing")
	`PPLI_ASSERT_NXT(a_result_follows, clk, arst_n, advance, m_axis_tvalid && (m_axis_tuser == $past(sample_s1)), "result word missing or of the wrong kind")

endmodule
